// ----- hw/rtl/idea_pkg.sv -----
package idea_pkg;

    localparam int ROUNDS = 8;
    localparam int NKEYS  = 6 * ROUNDS + 4;
    localparam int KAW    = $clog2(NKEYS);

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_DERIVE  = 2'd1;
    localparam logic [1:0] ACT_ENCRYPT = 2'd2;
    localparam logic [1:0] ACT_DECRYPT = 2'd3;

    // exponent for Fermat inverse: 65535 = all ones, 16 bits
    localparam logic [15:0] INV_EXP = 16'hFFFF;

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

endpackage

// ----- hw/rtl/idea_mul.sv -----
// Multiplier modulo 65537, zero stands for 65536. The product is
// registered, then reduced.
module idea_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  idea_pkg::mul_req_t req,
    output logic           done,
    output idea_pkg::word_t result
);
    import idea_pkg::*;

    logic [16:0] xa;
    logic [16:0] xb;
    logic [33:0] prod_reg;
    logic        vld_reg;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [17:0] diff;

    assign xa = (req.a == 16'd0) ? 17'h10000 : {1'b0, req.a};
    assign xb = (req.b == 16'd0) ? 17'h10000 : {1'b0, req.b};

    always_ff @(posedge clk)
    begin
        prod_reg <= xa * xb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= req.start;
        end
    end

    // p = hi*65536 + lo = lo - hi (mod 65537)
    assign lo   = {1'b0, prod_reg[15:0]};
    assign hi   = prod_reg[32:16];
    assign diff = {1'b0, lo} - {1'b0, hi};

    always_comb
    begin
        if (diff[17])
        begin
            result = 16'(diff + 18'd65537);
        end
        else
        begin
            result = diff[15:0];
        end
    end

    assign done = vld_reg;

endmodule

// ----- hw/rtl/idea_block_cipher.sv -----
// channel | dir | tdata fields (low bit up)                           | tuser
// s_axis  | in  | key_index[5:0] key_word word_one..word_four (88 b)  | action[1:0]
// m_axis  | out | out_one..out_four (64 b)                            | status
// One shared mod-65537 multiplier serves rounds, output transform and inverses.
// Encrypt/decrypt: 8 rounds, then the output transform, then the result
// is posted from S_OUT and held until taken.
// Decrypt before derive: error item valid the cycle after accept.
// Derive: 52 keys, with 18 inverses of 31 products each for nonzero
// multiply keys. Not ready while busy or while a result waits. rst_n
// clears control state only; subkey memories hold.
module idea_block_cipher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,  // key_index, key_word, word_one..four
    input  logic [1:0]   s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // out_one, out_two, out_three, out_four
    output logic         m_axis_tuser   // status
);
    import idea_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RMUL = 4'd1;  // issue a round product
    localparam logic [3:0] S_RWT  = 4'd2;  // wait for product
    localparam logic [3:0] S_DRD  = 4'd3;  // derive: read enc key
    localparam logic [3:0] S_DGET = 4'd4;  // derive: latch key
    localparam logic [3:0] S_DINV = 4'd5;  // inverse step issue
    localparam logic [3:0] S_DIWT = 4'd6;  // inverse step wait
    localparam logic [3:0] S_DWR  = 4'd7;  // derive: write dec key
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_KRD  = 4'd9;  // fetch round key

    logic [3:0]  state_reg, state_next;
    word_t       enc_mem [NKEYS];
    word_t       dec_mem [NKEYS];
    word_t       kq_reg;
    logic        dec_ready_reg;
    logic        sel_dec_reg;
    logic [KAW-1:0] kidx_reg;
    logic [2:0]  step_reg;
    logic [3:0]  rnd_reg;
    word_t       x1_reg, x2_reg, x3_reg, x4_reg, m_reg;
    word_t       base_reg, acc_reg, dk_reg;
    logic [4:0]  ebit_reg;
    logic        sq_reg;
    logic [KAW-1:0] dsrc_reg;
    logic [2:0]  dslot_reg;
    logic [3:0]  drnd_reg;
    logic [63:0] odata_reg;
    logic        ostat_reg, ovld_reg;
    mul_req_t    mreq;
    logic        mdone;
    word_t       mres;

    logic [1:0]  in_act;
    logic [5:0]  in_idx;
    logic        acc_in;

    assign in_act = s_axis_tuser;
    assign in_idx = s_axis_tdata[5:0];
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ovld_reg;
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ostat_reg;

    idea_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .done   (mdone),
        .result (mres)
    );

    // derive: destination index for source round j, slot sl
    function automatic logic [KAW-1:0] dec_dst(input logic [3:0] j, input logic [2:0] sl);
        logic [3:0] jd;
        logic [2:0] dl;
        begin
            dl = sl;
            if (sl < 3'd4)
            begin
                jd = 4'(ROUNDS) - j;
                if (j != 4'd0 && j != 4'(ROUNDS))
                begin
                    if (sl == 3'd1) dl = 3'd2;
                    if (sl == 3'd2) dl = 3'd1;
                end
            end
            else
            begin
                jd = 4'(ROUNDS - 1) - j;
            end
            dec_dst = KAW'(jd * 6 + dl);
        end
    endfunction

    logic [KAW-1:0] rkey_addr;
    assign rkey_addr = KAW'(rnd_reg * 6) + KAW'(step_reg);

    always_ff @(posedge clk)
    begin
        if (acc_in && in_act == ACT_LOAD && in_idx < 6'(NKEYS))
        begin
            enc_mem[in_idx[KAW-1:0]] <= s_axis_tdata[21:6];
        end
        if (state_reg == S_DWR)
        begin
            dec_mem[dec_dst(drnd_reg, dslot_reg)] <= dk_reg;
        end
        if (state_reg == S_DRD)
        begin
            kq_reg <= enc_mem[dsrc_reg];
        end
        else if (sel_dec_reg)
        begin
            kq_reg <= dec_mem[rkey_addr];
        end
        else
        begin
            kq_reg <= enc_mem[rkey_addr];
        end
    end

    always_comb
    begin
        mreq = '0;
        case (state_reg)
            S_RMUL:
            begin
                mreq.start = 1'b1;
                case (step_reg)
                    3'd0:    begin mreq.a = x1_reg; mreq.b = kq_reg; end
                    3'd3:    begin mreq.a = x4_reg; mreq.b = kq_reg; end
                    3'd4:    begin mreq.a = kq_reg; mreq.b = x1_reg ^ x3_reg; end
                    default: begin mreq.a = kq_reg;
                                   mreq.b = m_reg + (x2_reg ^ x4_reg); end
                endcase
            end
            S_DINV:
            begin
                mreq.start = 1'b1;
                mreq.a = sq_reg ? base_reg : acc_reg;
                mreq.b = base_reg;
            end
            default: mreq = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (in_act == ACT_DERIVE) state_next = S_DRD;
                    else if (in_act == ACT_ENCRYPT) state_next = S_KRD;
                    else if (in_act == ACT_DECRYPT && dec_ready_reg) state_next = S_KRD;
                end
            end
            S_KRD:  state_next = (step_reg == 3'd1 || step_reg == 3'd2) ? S_RWT : S_RMUL;
            S_RMUL: state_next = S_RWT;
            S_RWT:
            begin
                if (step_reg == 3'd1 || step_reg == 3'd2 || mdone)
                begin
                    if (rnd_reg == 4'(ROUNDS) && step_reg == 3'd3) state_next = S_OUT;
                    else state_next = S_KRD;
                end
            end
            S_DRD:  state_next = S_DGET;
            S_DGET: state_next = (dslot_reg == 3'd0 || dslot_reg == 3'd3) && kq_reg != 16'd0
                                 ? S_DINV : S_DWR;
            S_DINV: state_next = S_DIWT;
            S_DIWT:
            begin
                if (mdone)
                begin
                    // last multiply into the accumulator ends the inverse
                    if (!sq_reg && ebit_reg == 5'd1) state_next = S_DWR;
                    else state_next = S_DINV;
                end
            end
            S_DWR:  state_next = (dsrc_reg == KAW'(NKEYS - 1)) ? S_IDLE : S_DRD;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dec_ready_reg <= 1'b0;
            ovld_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_in && in_act == ACT_LOAD) dec_ready_reg <= 1'b0;
            if (state_reg == S_DWR && state_next == S_IDLE) dec_ready_reg <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) ovld_reg <= 1'b0;
            if (state_reg == S_OUT) ovld_reg <= 1'b1;
            if (acc_in && in_act == ACT_DECRYPT && !dec_ready_reg) ovld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x1_reg      <= s_axis_tdata[37:22];
                x2_reg      <= s_axis_tdata[53:38];
                x3_reg      <= s_axis_tdata[69:54];
                x4_reg      <= s_axis_tdata[85:70];
                sel_dec_reg <= (in_act == ACT_DECRYPT);
                rnd_reg     <= '0;
                step_reg    <= '0;
                dsrc_reg    <= '0;
                dslot_reg   <= '0;
                drnd_reg    <= '0;
                // a waiting result must hold until taken
                if (acc_in)
                begin
                    odata_reg <= '0;
                    ostat_reg <= 1'b1;
                end
            end
            S_RWT:
            begin
                if (rnd_reg == 4'(ROUNDS))
                begin
                    case (step_reg)
                        3'd0:    if (mdone) begin odata_reg[15:0] <= mres;
                                                  step_reg <= 3'd1; end
                        3'd1:    begin odata_reg[31:16] <= x3_reg + kq_reg;
                                       step_reg <= 3'd2; end
                        3'd2:    begin odata_reg[47:32] <= x2_reg + kq_reg;
                                       step_reg <= 3'd3; end
                        default: if (mdone) begin odata_reg[63:48] <= mres;
                                                  ostat_reg <= 1'b0; end
                    endcase
                end
                else
                begin
                    case (step_reg)
                        3'd0: if (mdone) begin x1_reg <= mres; step_reg <= 3'd1; end
                        3'd1: begin x2_reg <= x2_reg + kq_reg; step_reg <= 3'd2; end
                        3'd2: begin x3_reg <= x3_reg + kq_reg; step_reg <= 3'd3; end
                        3'd3: if (mdone) begin x4_reg <= mres; step_reg <= 3'd4; end
                        3'd4: if (mdone) begin m_reg <= mres; step_reg <= 3'd5; end
                        default:
                        begin
                            if (mdone)
                            begin
                                x1_reg   <= x1_reg ^ mres;
                                x4_reg   <= x4_reg ^ (m_reg + mres);
                                x2_reg   <= x3_reg ^ mres;
                                x3_reg   <= x2_reg ^ (m_reg + mres);
                                step_reg <= 3'd0;
                                rnd_reg  <= rnd_reg + 4'd1;
                            end
                        end
                    endcase
                end
            end
            S_DGET:
            begin
                base_reg <= kq_reg;
                acc_reg  <= 16'd1;
                ebit_reg <= 5'd16;
                sq_reg   <= 1'b0;
                if (dslot_reg == 3'd1 || dslot_reg == 3'd2) dk_reg <= 16'd0 - kq_reg;
                else dk_reg <= kq_reg;
            end
            S_DINV: ;
            S_DIWT:
            begin
                // right-to-left exponentiation; all exponent bits are one
                if (mdone)
                begin
                    if (sq_reg)
                    begin
                        base_reg <= mres;
                        sq_reg   <= 1'b0;
                    end
                    else
                    begin
                        acc_reg  <= mres;
                        dk_reg   <= mres;
                        ebit_reg <= ebit_reg - 5'd1;
                        sq_reg   <= (ebit_reg != 5'd1) && INV_EXP[0];
                    end
                end
            end
            S_DWR:
            begin
                dsrc_reg <= dsrc_reg + KAW'(1);
                if (dslot_reg == 3'd5)
                begin
                    dslot_reg <= 3'd0;
                    drnd_reg  <= drnd_reg + 4'd1;
                end
                else
                begin
                    dslot_reg <= dslot_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && in_act == ACT_LOAD) |=> !dec_ready_reg)
        else $error("dec_ready after load");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("error result nonzero");
`endif

endmodule
